FILE: design/h2t_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the HTML to text converter.
// No dependencies.
package h2t_pkg;

    localparam int MAX_NAME_LEN = 64;
    localparam int NAME_KEEP    = 6;
    localparam int NUM_OUT      = 6;
    localparam int CNT_W        = $clog2(NUM_OUT + 1);

    localparam logic [1:0] CS_SJIS = 2'd0;
    localparam logic [1:0] CS_EUC  = 2'd1;
    localparam logic [1:0] CS_UTF8 = 2'd2;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef struct packed {
        logic [NUM_OUT-1:0][7:0] bytes;
        logic [NUM_OUT-1:0]      lasts;
        logic [CNT_W-1:0]        count;
    } t_result;

endpackage

FILE: design/h2t_parse.sv
`timescale 1ns / 1ps
// Parser state and single-pass byte handling: builds the result bytes of one item.
// Depends on h2t_pkg.
module h2t_parse
    import h2t_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic [1:0] i_charset,
    output t_result    o_res
);

    typedef enum logic [2:0] {
        PH_TEXT    = 3'd0,
        PH_SPACE   = 3'd1,
        PH_LEAD    = 3'd2,
        PH_NAME    = 3'd3,
        PH_SKIP    = 3'd4,
        PH_COMMENT = 3'd5,
        PH_SCRIPT  = 3'd6
    } t_phase;

    localparam logic [6:0] LEN_SAT = 7'd127;

    logic [2:0]                  r_phase;
    logic [NAME_KEEP-1:0][7:0]   r_name;
    logic [6:0]                  r_len;
    logic [2:0]                  r_match;

    logic [2:0]                  n_phase;
    logic [NAME_KEEP-1:0][7:0]   n_name;
    logic [6:0]                  n_len;
    logic [2:0]                  n_match;

    logic [2:0]                  tk_phase;
    logic [NAME_KEEP-1:0][7:0]   tk_name;
    logic [6:0]                  tk_len;
    logic [2:0]                  tk_match;
    logic                        tk_emit;
    logic                        tk_fin;
    logic                        tk_fin_chr;

    logic [4:0][7:0]             fin_txt;
    logic [2:0]                  fin_n;
    logic [2:0]                  fin_ph;

    logic                        doc_end;
    logic                        fin;
    logic [2:0]                  a_n;
    logic [CNT_W-1:0]            res_cnt;
    logic [7:0]                  lc_byte;
    logic                        is_alpha;
    logic                        is_name_chr;
    logic [2:0]                  m_eff;

    function automatic logic [4:0][7:0] t5(
        input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
        input logic [7:0] b3, input logic [7:0] b4
    );
        return {b4, b3, b2, b1, b0};
    endfunction

    function automatic logic nm(
        input logic [NAME_KEEP-1:0][7:0] c, input logic [6:0] l,
        input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
        input logic [7:0] s3, input logic [7:0] s4, input logic [7:0] s5,
        input logic [6:0] n
    );
        return (l == n) && (c == {s5, s4, s3, s2, s1, s0});
    endfunction

    function automatic logic [7:0] script_chr(input logic [2:0] k);
        logic [7:0] r;
        case (k)
            3'd0:    r = "/";
            3'd1:    r = "s";
            3'd2:    r = "c";
            3'd3:    r = "r";
            3'd4:    r = "i";
            3'd5:    r = "p";
            3'd6:    r = "t";
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

    assign is_alpha    = ((i_byte >= "a") && (i_byte <= "z")) ||
                         ((i_byte >= "A") && (i_byte <= "Z"));
    assign is_name_chr = is_alpha || ((i_byte >= "0") && (i_byte <= "9")) ||
                         (i_byte == "/") || (i_byte == "!") || (i_byte == "-");
    assign lc_byte     = ((i_byte >= "A") && (i_byte <= "Z")) ? (i_byte + 8'h20) : i_byte;
    assign m_eff       = (r_match > 3'd6) ? 3'd0 : r_match;
    assign doc_end     = (i_byte == CH_NUL) || i_last;

    // handling of the byte itself
    always_comb begin
        tk_phase   = r_phase;
        tk_name    = r_name;
        tk_len     = r_len;
        tk_match   = r_match;
        tk_emit    = 1'b0;
        tk_fin     = 1'b0;
        tk_fin_chr = 1'b0;
        if (i_byte != CH_NUL) begin
            case (r_phase)
                PH_TEXT, PH_SPACE: begin
                    if (i_byte == "<") begin
                        tk_phase = PH_LEAD;
                    end else if (i_byte <= CH_SP) begin
                        tk_emit  = (r_phase == PH_TEXT);
                        tk_phase = PH_SPACE;
                    end else begin
                        tk_emit  = 1'b1;
                        tk_phase = PH_TEXT;
                    end
                end
                PH_LEAD: begin
                    if (i_byte > CH_SP) begin
                        if (is_alpha || (i_byte == "/") || (i_byte == "!")) begin
                            tk_name    = '0;
                            tk_name[0] = lc_byte;
                            tk_len     = 7'd1;
                            tk_phase   = PH_NAME;
                        end else if (i_byte == ">") begin
                            tk_phase = PH_TEXT;
                        end else begin
                            tk_phase = PH_SKIP;
                        end
                    end
                end
                PH_NAME: begin
                    if (is_name_chr) begin
                        if (r_len < 7'(NAME_KEEP)) begin
                            tk_name[r_len[2:0]] = lc_byte;
                        end
                        if (r_len != LEN_SAT) begin
                            tk_len = r_len + 7'd1;
                        end
                        tk_fin = (tk_len >= 7'(MAX_NAME_LEN));
                    end else begin
                        tk_fin     = 1'b1;
                        tk_fin_chr = 1'b1;
                    end
                end
                PH_COMMENT: begin
                    if ((r_match >= 3'd2) && (i_byte == ">")) begin
                        tk_match = 3'd0;
                        tk_phase = PH_TEXT;
                    end else if (i_byte == "-") begin
                        tk_match = (r_match >= 3'd1) ? 3'd2 : 3'd1;
                    end else begin
                        tk_match = 3'd0;
                    end
                end
                PH_SCRIPT: begin
                    if ((m_eff == 3'd6) && (i_byte == "t")) begin
                        tk_match = 3'd0;
                        tk_phase = PH_SKIP;
                    end else if (i_byte == "/") begin
                        tk_match = 3'd1;
                    end else if (i_byte == script_chr(m_eff)) begin
                        tk_match = m_eff + 3'd1;
                    end else begin
                        tk_match = 3'd0;
                    end
                end
                default: begin
                    if (i_byte == ">") begin
                        tk_phase = PH_TEXT;
                    end
                end
            endcase
        end
    end

    // finished tag name lookup
    always_comb begin
        fin_txt = '0;
        fin_n   = 3'd0;
        fin_ph  = PH_SKIP;
        if (nm(tk_name, tk_len, "l", "i", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2)) begin
            case (i_charset)
                CS_SJIS: begin
                    fin_txt = t5(CH_LF, CH_SP, 8'h81, 8'h45, CH_NUL);
                    fin_n   = 3'd4;
                end
                CS_EUC: begin
                    fin_txt = t5(CH_LF, CH_SP, 8'ha1, 8'ha6, CH_NUL);
                    fin_n   = 3'd4;
                end
                CS_UTF8: begin
                    fin_txt = t5(CH_LF, CH_SP, 8'he3, 8'h83, 8'hbb);
                    fin_n   = 3'd5;
                end
                default: begin
                    fin_txt = t5(CH_LF, CH_SP, CH_NUL, CH_NUL, CH_NUL);
                    fin_n   = 3'd2;
                end
            endcase
        end else if (nm(tk_name, tk_len, "b", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2) ||
                     nm(tk_name, tk_len, "/", "u", "l", CH_NUL, CH_NUL, CH_NUL, 7'd3) ||
                     nm(tk_name, tk_len, "/", "d", "l", CH_NUL, CH_NUL, CH_NUL, 7'd3) ||
                     nm(tk_name, tk_len, "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd1) ||
                     nm(tk_name, tk_len, "/", "p", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2) ||
                     nm(tk_name, tk_len, "/", "d", "i", "v", CH_NUL, CH_NUL, 7'd4)) begin
            fin_txt = t5(CH_LF, CH_NUL, CH_NUL, CH_NUL, CH_NUL);
            fin_n   = 3'd1;
        end else if (nm(tk_name, tk_len, "h", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2)) begin
            fin_txt = t5(CH_LF, "+", "+", CH_LF, CH_NUL);
            fin_n   = 3'd4;
        end else if (nm(tk_name, tk_len, "t", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2)) begin
            fin_txt = t5(CH_LF, CH_SP, CH_SP, CH_NUL, CH_NUL);
            fin_n   = 3'd3;
        end else if (nm(tk_name, tk_len, "t", "h", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2) ||
                     nm(tk_name, tk_len, "t", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2)) begin
            fin_txt = t5(CH_SP, "|", CH_SP, CH_NUL, CH_NUL);
            fin_n   = 3'd3;
        end else if (nm(tk_name, tk_len, "/", "t", "r", CH_NUL, CH_NUL, CH_NUL, 7'd3)) begin
            fin_txt = t5(CH_SP, "|", CH_NUL, CH_NUL, CH_NUL);
            fin_n   = 3'd2;
        end else if (nm(tk_name, tk_len, "d", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2)) begin
            fin_txt = t5(CH_LF, "*", CH_NUL, CH_NUL, CH_NUL);
            fin_n   = 3'd2;
        end else if (nm(tk_name, tk_len, "d", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2)) begin
            fin_txt = t5(CH_LF, CH_SP, "-", CH_SP, CH_NUL);
            fin_n   = 3'd4;
        end else if (nm(tk_name, tk_len, "h", "1", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2)) begin
            fin_txt = t5(CH_LF, "[", "[", CH_NUL, CH_NUL);
            fin_n   = 3'd3;
        end else if (nm(tk_name, tk_len, "h", "2", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2)) begin
            fin_txt = t5(CH_LF, "[", CH_NUL, CH_NUL, CH_NUL);
            fin_n   = 3'd2;
        end else if (nm(tk_name, tk_len, "h", "3", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2)) begin
            fin_txt = t5(CH_LF, "{", CH_NUL, CH_NUL, CH_NUL);
            fin_n   = 3'd2;
        end else if (nm(tk_name, tk_len, "h", "4", CH_NUL, CH_NUL, CH_NUL, CH_NUL, 7'd2)) begin
            fin_txt = t5(CH_LF, "(", CH_NUL, CH_NUL, CH_NUL);
            fin_n   = 3'd2;
        end else if (nm(tk_name, tk_len, "/", "h", "1", CH_NUL, CH_NUL, CH_NUL, 7'd3)) begin
            fin_txt = t5("]", "]", CH_LF, CH_NUL, CH_NUL);
            fin_n   = 3'd3;
        end else if (nm(tk_name, tk_len, "/", "h", "2", CH_NUL, CH_NUL, CH_NUL, 7'd3)) begin
            fin_txt = t5("]", CH_LF, CH_NUL, CH_NUL, CH_NUL);
            fin_n   = 3'd2;
        end else if (nm(tk_name, tk_len, "/", "h", "3", CH_NUL, CH_NUL, CH_NUL, 7'd3)) begin
            fin_txt = t5("}", CH_LF, CH_NUL, CH_NUL, CH_NUL);
            fin_n   = 3'd2;
        end else if (nm(tk_name, tk_len, "/", "h", "4", CH_NUL, CH_NUL, CH_NUL, 7'd3)) begin
            fin_txt = t5(")", CH_LF, CH_NUL, CH_NUL, CH_NUL);
            fin_n   = 3'd2;
        end else if (nm(tk_name, tk_len, "i", "m", "g", CH_NUL, CH_NUL, CH_NUL, 7'd3)) begin
            fin_txt = t5("[", "I", "M", "G", "]");
            fin_n   = 3'd5;
        end else if ((tk_len >= 7'd3) && (tk_name[0] == "!") && (tk_name[1] == "-") &&
                     (tk_name[2] == "-")) begin
            fin_ph = PH_COMMENT;
        end else if (nm(tk_name, tk_len, "s", "c", "r", "i", "p", "t", 7'd6)) begin
            fin_ph = PH_SCRIPT;
        end
    end

    // next state and result assembly
    always_comb begin
        fin     = tk_fin || (doc_end && (tk_phase == PH_NAME));
        n_phase = tk_phase;
        n_name  = tk_name;
        n_len   = tk_len;
        n_match = tk_match;
        if (doc_end) begin
            n_phase = PH_TEXT;
            n_name  = '0;
            n_len   = 7'd0;
            n_match = 3'd0;
        end else if (fin) begin
            n_match = 3'd0;
            if (tk_fin_chr && (fin_ph == PH_SKIP) && (i_byte == ">")) begin
                n_phase = PH_TEXT;
            end else begin
                n_phase = fin_ph;
            end
        end

        a_n     = fin ? fin_n : 3'd0;
        res_cnt = CNT_W'(a_n) + CNT_W'(tk_emit) + CNT_W'(doc_end);
        for (int i = 0; i < NUM_OUT; i++) begin
            o_res.lasts[i] = 1'b0;
            if (i < int'(a_n)) begin
                o_res.bytes[i] = fin_txt[i];
            end else if ((i == int'(a_n)) && tk_emit) begin
                o_res.bytes[i] = (i_byte <= CH_SP) ? CH_SP : i_byte;
            end else begin
                o_res.bytes[i] = CH_LF;
                o_res.lasts[i] = doc_end && (i == int'(res_cnt) - 1);
            end
        end
        o_res.count = res_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_name  <= '0;
            r_len   <= 7'd0;
            r_match <= 3'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_name  <= n_name;
            r_len   <= n_len;
            r_match <= n_match;
        end
    end

endmodule

FILE: design/html_to_text_converter.sv
`timescale 1ns / 1ps
// HTML to plain text converter, top level: input register, parser, output byte buffer.
// Depends on h2t_pkg and h2t_parse.
//
// One document byte enters per transfer and leaves as zero to six text bytes.
// An input byte is held in an input register, handled in one pass, and its
// output bytes are loaded into a six-entry buffer that drains one byte per
// cycle while the output is ready; the input side keeps accepting while the
// buffer drains its last byte. So plain text streams at one byte per cycle
// while the output is ready, and an item that yields more bytes holds the
// input until the buffer is down to its last byte (tag texts up to five
// bytes, plus the closing newline at the end of a document). The first
// output byte of an item passes the input register and then the buffer.
// The charset register may only be written while idle.
module html_to_text_converter
    import h2t_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_charset_we,
    input  logic [1:0] i_charset_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic [1:0]              r_charset;
    logic                    r_in_vld;
    logic [7:0]              r_in_byte;
    logic                    r_in_last;
    logic [NUM_OUT-1:0][7:0] r_buf;
    logic [NUM_OUT-1:0]      r_lst;
    logic [CNT_W-1:0]        r_cnt;

    logic                    proc;
    logic                    out_xfer;
    t_result                 res;

    assign out_xfer = o_valid && i_ready;
    assign proc     = r_in_vld && ((r_cnt == '0) ||
                      ((r_cnt == CNT_W'(1)) && i_ready));
    assign o_ready  = !r_in_vld || proc;
    assign o_valid  = (r_cnt != '0);
    assign o_out_byte = r_buf[0];
    assign o_out_last = r_lst[0];

    h2t_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (proc),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_charset (r_charset),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charset <= CS_SJIS;
        end else if (i_charset_we) begin
            r_charset <= i_charset_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_vld <= 1'b1;
        end else if (proc) begin
            r_in_vld <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_lst <= '0;
        end else if (proc) begin
            r_cnt <= res.count;
            r_lst <= res.lasts;
        end else if (out_xfer) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_lst <= {1'b0, r_lst[NUM_OUT-1:1]};
        end
        if (proc) begin
            r_buf <= res.bytes;
        end else if (out_xfer) begin
            r_buf <= {CH_NUL, r_buf[NUM_OUT-1:1]};
        end
    end

endmodule

FILE: design/h2t_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the HTML to text converter, bound to the top level.
// Depends on html_to_text_converter.
module h2t_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);

    // stalled output transfer holds its byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_out_last))
        else $error("output changed while stalled");

    // reset empties the output buffer
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // the end-of-document flag only rides on a newline
    a_last_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_last |-> o_out_byte == 8'h0a)
        else $error("last flag on a byte other than newline");

    // with nothing pending at the output the input side is open
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked while output buffer is empty");

endmodule

bind html_to_text_converter h2t_checker u_h2t_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_byte (o_out_byte),
    .o_out_last (o_out_last)
);

FILE: tb/sv/html_to_text_checker.sv
`timescale 1ns / 1ps
// Checker for the HTML to text converter: watches both channels and the charset port,
// predicts the text bytes of each input transfer and compares them in order.
// Depends on h2t_pkg.
module html_to_text_checker
    import h2t_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_charset_we,
    input  logic [1:0] i_charset_wdata,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    typedef enum logic [2:0] {
        ST_TEXT,
        ST_BLANK,
        ST_OPEN,
        ST_NAME,
        ST_DROP,
        ST_COMMENT,
        ST_SCRIPT
    } t_parse_state;

    localparam logic [55:0] SCRIPT_CLOSE = "/script";

    t_parse_state pstate = ST_TEXT;
    logic [7:0]   tag_chars [NAME_KEEP];
    logic [6:0]   tag_len = '0;
    logic [2:0]   close_cnt = '0;
    logic [1:0]   bullet_set = CS_SJIS;
    int           step_count = 0;
    int           fails = 0;
    int           pending = 0;
    int           checked = 0;
    logic [8:0]   expected_text_q [$];
    logic [8:0]   want;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_checked    = checked;

    function void flag(input string msg);
        if (fails < 10) begin
            $display("[%0t] %s", $time, msg);
        end
        fails++;
    endfunction

    function void put_text(input logic [7:0] b, input logic l);
        if (step_count < NUM_OUT) begin
            expected_text_q.push_back({l, b});
            step_count++;
        end
    endfunction

    function void put_string(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_text(s[i], 1'b0);
        end
    endfunction

    function automatic logic is_tag_char(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == "/" || b == "!" || b == "-";
    endfunction

    function void clear_tag();
        for (int i = 0; i < NAME_KEEP; i++) begin
            tag_chars[i] = '0;
        end
        tag_len = '0;
    endfunction

    function void append_tag_char(input logic [7:0] b);
        logic [7:0] c;
        c = (b >= "A" && b <= "Z") ? b + 8'h20 : b;
        if (tag_len < NAME_KEEP) begin
            tag_chars[tag_len] = c;
        end
        if (tag_len < 7'd127) begin
            tag_len++;
        end
    endfunction

    // name packed right-aligned so it compares directly with string literals
    function automatic logic [47:0] tag_key();
        logic [47:0] k;
        k = '0;
        if (tag_len <= NAME_KEEP) begin
            for (int i = 0; i < NAME_KEEP; i++) begin
                if (i < tag_len) begin
                    k = {k[39:0], tag_chars[i]};
                end
            end
        end
        return k;
    endfunction

    function t_parse_state close_tag();
        t_parse_state nxt;
        logic [47:0]  key;
        nxt       = ST_DROP;
        key       = tag_key();
        close_cnt = '0;
        case (key)
            "li": begin
                put_string("\n ");
                case (bullet_set)
                    CS_SJIS: begin
                        put_text(8'h81, 1'b0);
                        put_text(8'h45, 1'b0);
                    end
                    CS_EUC: begin
                        put_text(8'ha1, 1'b0);
                        put_text(8'ha6, 1'b0);
                    end
                    CS_UTF8: begin
                        put_text(8'he3, 1'b0);
                        put_text(8'h83, 1'b0);
                        put_text(8'hbb, 1'b0);
                    end
                    default: ;
                endcase
            end
            "br", "/ul", "/dl", "p", "/p", "/div": put_string("\n");
            "hr": put_string("\n++\n");
            "tr": put_string("\n  ");
            "th", "td": put_string(" | ");
            "/tr": put_string(" |");
            "dt": put_string("\n*");
            "dd": put_string("\n - ");
            "h1": put_string("\n[[");
            "h2": put_string("\n[");
            "h3": put_string("\n{");
            "h4": put_string("\n(");
            "/h1": put_string("]]\n");
            "/h2": put_string("]\n");
            "/h3": put_string("}\n");
            "/h4": put_string(")\n");
            "img": put_string("[IMG]");
            "script": nxt = ST_SCRIPT;
            default: begin
                if (tag_len >= 3 && tag_chars[0] == "!" && tag_chars[1] == "-" &&
                    tag_chars[2] == "-") begin
                    nxt = ST_COMMENT;
                end
            end
        endcase
        return nxt;
    endfunction

    function void take_byte(input logic [7:0] b);
        // a byte that ends a name is handled again in the state the name leads to
        if (pstate == ST_NAME && !is_tag_char(b)) begin
            pstate = close_tag();
        end
        case (pstate)
            ST_TEXT, ST_BLANK: begin
                if (b == "<") begin
                    pstate = ST_OPEN;
                end else if (b <= CH_SP) begin
                    if (pstate == ST_TEXT) begin
                        put_text(CH_SP, 1'b0);
                    end
                    pstate = ST_BLANK;
                end else begin
                    put_text(b, 1'b0);
                    pstate = ST_TEXT;
                end
            end
            ST_OPEN: begin
                if (b > CH_SP) begin
                    if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                        b == "/" || b == "!") begin
                        clear_tag();
                        append_tag_char(b);
                        pstate = ST_NAME;
                    end else begin
                        pstate = (b == ">") ? ST_TEXT : ST_DROP;
                    end
                end
            end
            ST_NAME: begin
                append_tag_char(b);
                if (tag_len >= MAX_NAME_LEN) begin
                    pstate = close_tag();
                end
            end
            ST_COMMENT: begin
                if (close_cnt >= 2 && b == ">") begin
                    close_cnt = '0;
                    pstate    = ST_TEXT;
                end else if (b == "-") begin
                    close_cnt = (close_cnt >= 1) ? 3'd2 : 3'd1;
                end else begin
                    close_cnt = '0;
                end
            end
            ST_SCRIPT: begin
                if (close_cnt > 6) begin
                    close_cnt = '0;
                end
                if (close_cnt == 6 && b == "t") begin
                    close_cnt = '0;
                    pstate    = ST_DROP;
                end else if (b == "/") begin
                    close_cnt = 3'd1;
                end else if (b == SCRIPT_CLOSE[8 * (6 - int'(close_cnt)) +: 8]) begin
                    close_cnt++;
                end else begin
                    close_cnt = '0;
                end
            end
            default: begin
                if (b == ">") begin
                    pstate = ST_TEXT;
                end
            end
        endcase
    endfunction

    function void clear_parse();
        pstate    = ST_TEXT;
        close_cnt = '0;
        clear_tag();
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bullet_set = CS_SJIS;
            clear_parse();
            expected_text_q.delete();
        end else begin
            if (i_charset_we) begin
                bullet_set = i_charset_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                step_count = 0;
                if (i_in_byte != CH_NUL) begin
                    take_byte(i_in_byte);
                end
                // end of document: pending name is acted on, then the closing newline
                if (i_in_byte == CH_NUL || i_in_last) begin
                    if (pstate == ST_NAME) begin
                        void'(close_tag());
                    end
                    put_text(CH_LF, 1'b1);
                    clear_parse();
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_text_q.size() == 0) begin
                    flag($sformatf("unexpected transfer: out_byte %02h out_last %0d",
                                   i_out_byte, i_out_last));
                end else begin
                    want = expected_text_q.pop_front();
                    checked++;
                    if (want[7:0] !== i_out_byte) begin
                        flag($sformatf("out_byte mismatch: expected %02h, got %02h",
                                       want[7:0], i_out_byte));
                    end
                    if (want[8] !== i_out_last) begin
                        flag($sformatf("out_last mismatch: expected %0d, got %0d (byte %02h)",
                                       want[8], i_out_last, i_out_byte));
                    end
                end
            end
        end
        pending = expected_text_q.size();
    end

endmodule

FILE: tb/sv/html_to_text_converter_test.sv
`timescale 1ns / 1ps
// Top of the HTML to text converter test: clock, reset, charset writes, document
// stimulus and random ready stalls; checking is done in html_to_text_checker.
// Depends on h2t_pkg, html_to_text_converter and html_to_text_checker.
module html_to_text_converter_test;
    import h2t_pkg::*;

    localparam logic [1:0] CS_NONE = 2'd3;
    localparam int         NUM_ITEMS = 480;
    localparam int         QUIET_FROM = 400;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       charset_we = 1'b0;
    logic [1:0] charset_wdata = CS_SJIS;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = CH_NUL;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;

    int fail_count;
    int pending;
    int checked;

    int items = 0;
    int docs = 0;
    int stall_left = 0;
    bit quiet = 1'b0;
    bit calm = 1'b0;
    bit doc_last;

    logic [7:0] doc_q [$];

    string tag_names [0:21] = '{"br", "hr", "tr", "th", "td", "/tr", "/ul", "dt", "dd",
                                "/dl", "p", "/p", "/div", "h1", "h2", "h3", "h4", "/h1",
                                "/h2", "/h3", "/h4", "img"};
    string name_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHXYZ0123456789-/!";
    string comment_pool = "-->a! ";
    string script_pool = "</scriptX> ";
    string lead_pool = " >3=.\"";

    html_to_text_converter dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_charset_we   (charset_we),
        .i_charset_wdata(charset_wdata),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_in_byte      (in_byte),
        .i_in_last      (in_last),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_out_byte     (out_byte),
        .o_out_last     (out_last)
    );

    html_to_text_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_charset_we   (charset_we),
        .i_charset_wdata(charset_wdata),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_byte      (in_byte),
        .i_in_last      (in_last),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_byte     (out_byte),
        .i_out_last     (out_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // output side stalls in bursts of random length
    always @(posedge clk) begin
        if (quiet || calm) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task send_item(input logic [7:0] b, input logic l);
        if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        do @(posedge clk); while (!in_ready);
        items++;
        if (items >= QUIET_FROM) begin
            quiet = 1'b1;
        end
    endtask

    task send_doc(input bit with_last);
        for (int i = 0; i < doc_q.size(); i++) begin
            send_item(doc_q[i], with_last && i == doc_q.size() - 1);
        end
        doc_q.delete();
        docs++;
    endtask

    task wait_drained();
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task write_charset(input logic [1:0] v);
        in_valid <= 1'b0;
        wait_drained();
        // bytes with no text output may still be in flight
        repeat (8) @(posedge clk);
        charset_we    <= 1'b1;
        charset_wdata <= v;
        @(posedge clk);
        charset_we <= 1'b0;
    endtask

    task add_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            doc_q.push_back(s[i]);
        end
    endtask

    task add_name(input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c >= "a" && c <= "z" && $urandom_range(0, 2) == 0) begin
                c = c - 8'h20;
            end
            doc_q.push_back(c);
        end
    endtask

    task add_tag(input string nm);
        doc_q.push_back("<");
        if ($urandom_range(0, 3) == 0) begin
            doc_q.push_back(" ");
        end
        add_name(nm);
        if ($urandom_range(0, 3) == 0) begin
            add_str(" a=1");
        end
        doc_q.push_back(">");
    endtask

    function automatic logic [7:0] pick(input string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task build_doc(output bit with_last);
        logic [7:0] b;
        repeat ($urandom_range(3, 10)) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 6)) begin
                        b = 8'($urandom_range(8'h21, 8'hff));
                        doc_q.push_back((b == "<") ? 8'h26 : b);
                    end
                end
                4, 5: begin
                    repeat ($urandom_range(1, 3)) doc_q.push_back(8'($urandom_range(1, 32)));
                end
                6, 7, 8: add_tag(tag_names[$urandom_range(0, 21)]);
                9: add_tag("li");
                10: begin
                    doc_q.push_back("<");
                    repeat ($urandom_range(1, 8)) doc_q.push_back(pick(name_pool));
                    doc_q.push_back(">");
                end
                11: begin
                    add_str("<!--");
                    repeat ($urandom_range(0, 8)) doc_q.push_back(pick(comment_pool));
                    if ($urandom_range(0, 5) != 0) begin
                        add_str("-->");
                    end
                end
                12: begin
                    add_tag("script");
                    repeat ($urandom_range(0, 10)) doc_q.push_back(pick(script_pool));
                    if ($urandom_range(0, 5) != 0) begin
                        add_str("</script>");
                    end
                end
                13: begin
                    // name at and past the length limit
                    doc_q.push_back("<");
                    doc_q.push_back("q");
                    repeat ($urandom_range(61, 69)) doc_q.push_back(pick(name_pool));
                    doc_q.push_back(">");
                end
                14: doc_q.push_back(8'($urandom_range(1, 255)));
                default: begin
                    doc_q.push_back("<");
                    doc_q.push_back(pick(lead_pool));
                end
            endcase
        end
        with_last = 1'b1;
        case ($urandom_range(0, 3))
            0: begin
                if (doc_q.size() == 0) begin
                    doc_q.push_back("z");
                end
            end
            1: begin
                doc_q.push_back(CH_NUL);
                with_last = 1'b0;
            end
            2: doc_q.push_back(CH_NUL);
            default: begin
                doc_q.push_back("<");
                add_name(tag_names[$urandom_range(0, 21)]);
            end
        endcase
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        write_charset(CS_UTF8);
        doc_q.push_back(8'hff);
        doc_q.push_back(8'h01);
        add_str(" x< Li>A");
        send_doc(1'b1);
        write_charset(CS_NONE);
        add_str("<li");
        doc_q.push_back(CH_NUL);
        send_doc(1'b0);
        write_charset(CS_SJIS);
        doc_q.push_back(CH_NUL);
        send_doc(1'b1);
        add_str("<!--x");
        send_doc(1'b1);
        add_str("<hR");
        send_doc(1'b1);

        write_charset(CS_EUC);
        while (items < NUM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                write_charset(2'($urandom_range(0, 3)));
            end
            calm = ($urandom_range(0, 4) == 0);
            build_doc(doc_last);
            send_doc(doc_last);
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (pending != 0) begin
            $display("%0d expected text bytes never arrived", pending);
        end
        $display("covered %0d documents, %0d input bytes, %0d text bytes checked,",
                 docs, items, checked);
        $display("with all four charset settings, comments, scripts and over-long names");
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout waiting for transfers");
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: html_to_text_converter.f
design/h2t_pkg.sv
design/h2t_parse.sv
design/html_to_text_converter.sv
design/h2t_checker.sv
tb/sv/html_to_text_checker.sv
tb/sv/html_to_text_converter_test.sv
